>>> hw/rtl/line_pixel_stepper_macros.svh
// assertion helpers for the line stepper back side (lps_back)
`ifndef LINE_PIXEL_STEPPER_MACROS_SVH
`define LINE_PIXEL_STEPPER_MACROS_SVH

`ifndef ASSERT_OFF
// checked only outside reset
`define LPS_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("line stepper assertion failed");
// checked on every edge, reset included
`define LPS_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("line stepper reset assertion failed");
`else
`define LPS_ASSERT(lbl, prop)
`define LPS_ASSERT_ALWAYS(lbl, prop)
`endif

`endif

>>> hw/rtl/lps_pkg.sv
package lps_pkg;

  // coordinate width of every endpoint and pixel
  localparam int unsigned COORD_BITS = 12;
  // folded deltas are never negative and never exceed 2^COORD_BITS - 1
  localparam int unsigned DELTA_W    = COORD_BITS;
  // pixel count reaches major delta plus one
  localparam int unsigned CNT_W      = COORD_BITS + 1;
  // decision value stays within twice the largest delta, either sign
  localparam int unsigned ERR_W      = DELTA_W + 2;

  // command queue, depth a power of two
  localparam int unsigned FIFO_DEPTH = 2;
  localparam int unsigned FIFO_PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int unsigned FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic [DELTA_W-1:0]           delta_t;

  typedef enum logic {
    OP_START = 1'b0,
    OP_STEP  = 1'b1
  } lps_op_e;

  typedef struct packed {
    logic mir_y;
    logic mir_x;
    logic swap;
  } fold_t;

  typedef struct packed {
    logic   mode;
    coord_t x_start;
    coord_t y_start;
    coord_t x_end;
    coord_t y_end;
  } lps_in_t;

  typedef struct packed {
    coord_t pixel_x;
    coord_t pixel_y;
    logic   last_pixel;
  } lps_out_t;

  typedef struct packed {
    lps_op_e op;
    fold_t   fold;
    coord_t  major_pos;
    coord_t  minor_pos;
    delta_t  major_delta;
    delta_t  minor_delta;
  } lps_cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

endpackage

>>> hw/rtl/lps_front.sv
module lps_front (
  input  lps_pkg::lps_in_t  in_i,
  output lps_pkg::lps_cmd_t cmd_o
);
  import lps_pkg::*;

  logic signed [COORD_BITS:0] dx, dy, dx_s, dy_s, dx_m, dy_m;
  coord_t xa_s, ya_s, xa_m, ya_m;
  logic   both_neg;
  fold_t  fold;

  always_comb begin
    dx = {in_i.x_end[COORD_BITS-1], in_i.x_end} - {in_i.x_start[COORD_BITS-1], in_i.x_start};
    dy = {in_i.y_end[COORD_BITS-1], in_i.y_end} - {in_i.y_start[COORD_BITS-1], in_i.y_start};
    both_neg = dx[COORD_BITS] & dy[COORD_BITS];

    // both deltas negative: walk the line from the other end
    if (both_neg) begin
      xa_s = in_i.x_end;
      ya_s = in_i.y_end;
      dx_s = -dx;
      dy_s = -dy;
    end else begin
      xa_s = in_i.x_start;
      ya_s = in_i.y_start;
      dx_s = dx;
      dy_s = dy;
    end

    fold.mir_x = dx_s[COORD_BITS];
    fold.mir_y = dy_s[COORD_BITS];
    xa_m = fold.mir_x ? -xa_s : xa_s;
    dx_m = fold.mir_x ? -dx_s : dx_s;
    ya_m = fold.mir_y ? -ya_s : ya_s;
    dy_m = fold.mir_y ? -dy_s : dy_s;

    fold.swap = dy_m[DELTA_W-1:0] > dx_m[DELTA_W-1:0];

    cmd_o.op   = lps_op_e'(in_i.mode);
    cmd_o.fold = fold;
    if (fold.swap) begin
      cmd_o.major_pos   = ya_m;
      cmd_o.minor_pos   = xa_m;
      cmd_o.major_delta = dy_m[DELTA_W-1:0];
      cmd_o.minor_delta = dx_m[DELTA_W-1:0];
    end else begin
      cmd_o.major_pos   = xa_m;
      cmd_o.minor_pos   = ya_m;
      cmd_o.major_delta = dx_m[DELTA_W-1:0];
      cmd_o.minor_delta = dy_m[DELTA_W-1:0];
    end
  end

endmodule

>>> hw/rtl/lps_cmd_fifo.sv
module lps_cmd_fifo (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  lps_pkg::lps_cmd_t    data_i,
  input  logic                 pop_i,
  output lps_pkg::lps_cmd_t    data_o,
  output lps_pkg::fifo_stat_t  stat_o
);
  import lps_pkg::*;

  lps_cmd_t              mem_q [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [FIFO_CNT_W-1:0] cnt_q, cnt_d;

  assign stat_o.full  = (cnt_q == FIFO_CNT_W'(FIFO_DEPTH));
  assign stat_o.empty = (cnt_q == '0);
  assign data_o       = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + FIFO_PTR_W'(1) : wr_ptr_q;
    rd_ptr_d = pop_i  ? rd_ptr_q + FIFO_PTR_W'(1) : rd_ptr_q;
    case ({push_i, pop_i})
      2'b10:   cnt_d = cnt_q + FIFO_CNT_W'(1);
      2'b01:   cnt_d = cnt_q - FIFO_CNT_W'(1);
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule

>>> hw/rtl/lps_back.sv
`include "line_pixel_stepper_macros.svh"

module lps_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  lps_pkg::lps_cmd_t  cmd_i,
  input  logic               cmd_valid_i,
  output logic               cmd_pop_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output lps_pkg::lps_out_t  out_data_o
);
  import lps_pkg::*;

  logic                    active_q, active_d;
  coord_t                  major_pos_q, major_pos_d, minor_pos_q, minor_pos_d;
  logic signed [ERR_W-1:0] err_q, err_d, inc_diag_q, inc_diag_d, inc_axial_q, inc_axial_d;
  logic [CNT_W-1:0]        left_q, left_d;
  fold_t                   fold_q, fold_d;
  logic                    out_valid_q, out_valid_d;
  lps_out_t                out_q, out_d;

  logic                    out_free, is_start, emit, start;
  logic signed [ERR_W-1:0] two_dy, two_dx, dx_e;
  coord_t                  px, py;

  always_comb begin
    out_free  = !out_valid_q || out_ready_i;
    is_start  = (cmd_i.op == OP_START);
    cmd_pop_o = cmd_valid_i && (is_start || !active_q || out_free);
    start     = cmd_valid_i && is_start;
    emit      = cmd_valid_i && !is_start && active_q && out_free;

    two_dy = {1'b0, cmd_i.minor_delta, 1'b0};
    two_dx = {1'b0, cmd_i.major_delta, 1'b0};
    dx_e   = {2'b00, cmd_i.major_delta};

    px = fold_q.swap ? minor_pos_q : major_pos_q;
    py = fold_q.swap ? major_pos_q : minor_pos_q;
    if (fold_q.mir_x) begin
      px = -px;
    end
    if (fold_q.mir_y) begin
      py = -py;
    end

    active_d    = active_q;
    major_pos_d = major_pos_q;
    minor_pos_d = minor_pos_q;
    err_d       = err_q;
    inc_diag_d  = inc_diag_q;
    inc_axial_d = inc_axial_q;
    left_d      = left_q;
    fold_d      = fold_q;

    if (start) begin
      fold_d      = cmd_i.fold;
      major_pos_d = cmd_i.major_pos;
      minor_pos_d = cmd_i.minor_pos;
      err_d       = two_dy - dx_e;
      inc_diag_d  = two_dy - two_dx;
      inc_axial_d = two_dy;
      // a zero length line draws nothing
      active_d    = (cmd_i.major_delta != '0);
      left_d      = {1'b0, cmd_i.major_delta} + CNT_W'(1);
    end else if (emit) begin
      if (!err_q[ERR_W-1]) begin
        minor_pos_d = minor_pos_q + COORD_BITS'(1);
        err_d       = err_q + inc_diag_q;
      end else begin
        err_d       = err_q + inc_axial_q;
      end
      major_pos_d = major_pos_q + COORD_BITS'(1);
      left_d      = left_q - CNT_W'(1);
      active_d    = (left_q != CNT_W'(1));
    end

    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (emit) begin
      out_valid_d      = 1'b1;
      out_d.pixel_x    = px;
      out_d.pixel_y    = py;
      out_d.last_pixel = (left_q == CNT_W'(1));
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      active_q    <= active_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    major_pos_q <= major_pos_d;
    minor_pos_q <= minor_pos_d;
    err_q       <= err_d;
    inc_diag_q  <= inc_diag_d;
    inc_axial_q <= inc_axial_d;
    left_q      <= left_d;
    fold_q      <= fold_d;
    out_q       <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `LPS_ASSERT(a_active_has_pixels, active_q |-> (left_q != '0))
  `LPS_ASSERT(a_last_ends_line, (emit && (left_q == CNT_W'(1))) |=> !active_q)
  `LPS_ASSERT(a_folded_octant, active_q |-> (inc_diag_q[ERR_W-1] || (inc_diag_q == '0)))
  `LPS_ASSERT_ALWAYS(a_reset_no_beat, !rst_ni |=> !out_valid_q)

endmodule

>>> hw/rtl/line_pixel_stepper.sv
// bresenham line rasteriser. a start beat (mode 0) loads two signed endpoints and
// produces nothing; each step beat (mode 1) then yields the next pixel of the line in
// the original coordinates, major length plus one pixels in all, the last one flagged
// by last_pixel. every octant is handled, equal endpoints draw nothing, a step with no
// line running is swallowed, and a start during a line abandons it. one input beat is
// taken every clock and one pixel leaves every clock while out_ready_i holds; each
// step beat passes the two-entry command queue and its pixel the output register.
// a stalled output fills the queue after two beats and then holds off the input.
module line_pixel_stepper (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  lps_pkg::lps_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output lps_pkg::lps_out_t out_data_o
);
  import lps_pkg::*;

  // front side: fold each start beat into the first octant
  lps_cmd_t   front_cmd;
  // queue between folding and stepping
  lps_cmd_t   queue_cmd;
  fifo_stat_t queue_stat;
  logic       queue_push, queue_pop;

  assign in_ready_o = !queue_stat.full;
  assign queue_push = in_valid_i && in_ready_o;

  lps_front u_front (
    .in_i  (in_data_i),
    .cmd_o (front_cmd)
  );

  lps_cmd_fifo u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (queue_push),
    .data_i (front_cmd),
    .pop_i  (queue_pop),
    .data_o (queue_cmd),
    .stat_o (queue_stat)
  );

  // back side: one add and compare on the running decision value per pixel
  lps_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (queue_cmd),
    .cmd_valid_i (!queue_stat.empty),
    .cmd_pop_o   (queue_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

>>> tb/line_pixel_stepper_test.sv
module line_pixel_stepper_test;
  timeunit 1ns;
  timeprecision 1ps;

  import lps_pkg::*;

  // cycles without any beat on either side before the run is called hung
  localparam int unsigned WATCHDOG_LIMIT = 1000;
  // settling time after the last pixel has left
  localparam int unsigned SETTLE_CYCLES  = 8;
  // rough number of line beats in the random part
  localparam int unsigned RANDOM_BEATS   = 600;

  // one queued input beat; drain holds it back until every pixel due has left
  typedef struct {
    lps_in_t beat;
    bit      drain;
  } queued_beat_t;

  logic     clk_i     = 1'b0;
  logic     rst_n     = 1'b0;
  logic     in_valid  = 1'b0;
  logic     in_ready;
  lps_in_t  in_data   = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  lps_out_t out_data;

  queued_beat_t beats_to_send[$];
  lps_out_t     pixels_due[$];

  int unsigned mismatch_count = 0;
  int unsigned stuck_cycles   = 0;
  bit          all_drawn      = 1'b1;

  // driver bookkeeping
  int unsigned burst_left = 0;
  int unsigned gap_left   = 0;
  bit          drain_seen = 1'b0;

  // receiver stall pattern
  logic [15:0] stall_pattern = 16'hffff;
  logic [7:0]  pattern_age   = '0;

  // rasteriser copy: folded position, decision value and spans of the running line
  bit    line_busy   = 1'b0;
  int    run_major   = 0;
  int    run_minor   = 0;
  int    decision    = 0;
  int    span_major  = 0;
  int    span_minor  = 0;
  int    pixels_left = 0;
  fold_t line_fold   = '0;

  lps_out_t due_pixel;
  lps_out_t fresh_pixel;
  bit       fresh_valid;

  line_pixel_stepper i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // one line per mismatch, counted for the final verdict
  task automatic flag_mismatch(input string what);
    mismatch_count++;
    $display("mismatch at %0t: %s", $realtime, what);
  endtask

  // advance the rasteriser by one accepted beat; a start folds the line into the
  // first octant, a step emits the next pixel unfolded back to screen coordinates
  task automatic raster_next(input lps_in_t beat, output bit emits, output lps_out_t pix);
    int    xa;
    int    ya;
    int    xb;
    int    yb;
    int    dx;
    int    dy;
    int    t;
    int    px;
    int    py;
    fold_t fold;
    emits = 1'b0;
    pix   = '0;
    if (beat.mode == OP_START) begin
      xa   = beat.x_start;
      ya   = beat.y_start;
      xb   = beat.x_end;
      yb   = beat.y_end;
      dx   = xb - xa;
      dy   = yb - ya;
      fold = '0;
      // both deltas negative: draw from the other end instead
      if (dx < 0 && dy < 0) begin
        xa = xb;
        ya = yb;
        dx = -dx;
        dy = -dy;
      end
      if (dx < 0) begin
        fold.mir_x = 1'b1;
        xa = -xa;
        dx = -dx;
      end
      if (dy < 0) begin
        fold.mir_y = 1'b1;
        ya = -ya;
        dy = -dy;
      end
      // steep line: y becomes the major axis
      if (dy > dx) begin
        fold.swap = 1'b1;
        t  = dx;
        dx = dy;
        dy = t;
        t  = xa;
        xa = ya;
        ya = t;
      end
      line_fold   = fold;
      run_major   = xa;
      run_minor   = ya;
      span_major  = dx;
      span_minor  = dy;
      decision    = 2 * dy - dx;
      // a zero-length line draws nothing at all
      line_busy   = (dx != 0);
      pixels_left = (dx == 0) ? 0 : dx + 1;
    end else if (line_busy) begin
      if (line_fold.swap) begin
        px = run_minor;
        py = run_major;
      end else begin
        px = run_major;
        py = run_minor;
      end
      if (line_fold.mir_y) py = -py;
      if (line_fold.mir_x) px = -px;
      pix.pixel_x    = px[COORD_BITS-1:0];
      pix.pixel_y    = py[COORD_BITS-1:0];
      pix.last_pixel = (pixels_left == 1);
      emits          = 1'b1;
      if (decision >= 0) begin
        run_minor++;
        decision += 2 * (span_minor - span_major);
      end else begin
        decision += 2 * span_minor;
      end
      run_major++;
      pixels_left--;
      if (pixels_left == 0) line_busy = 1'b0;
    end
  endtask

  function automatic int rand_coord();
    return int'($urandom_range(0, 4095)) - 2048;
  endfunction

  function automatic int clamp_coord(input int c);
    if (c > 2047) return 2047;
    if (c < -2048) return -2048;
    return c;
  endfunction

  task automatic queue_start(input int x0, input int y0, input int x1, input int y1,
                             input bit drain);
    queued_beat_t qb;
    qb.beat.mode    = OP_START;
    qb.beat.x_start = x0[COORD_BITS-1:0];
    qb.beat.y_start = y0[COORD_BITS-1:0];
    qb.beat.x_end   = x1[COORD_BITS-1:0];
    qb.beat.y_end   = y1[COORD_BITS-1:0];
    qb.drain        = drain;
    beats_to_send   = {beats_to_send, qb};
  endtask

  // step beats carry junk coordinates so those bits toggle while ignored
  task automatic queue_steps(input int n);
    queued_beat_t qb;
    for (int i = 0; i < n; i++) begin
      qb.beat.mode    = OP_STEP;
      qb.beat.x_start = coord_t'($urandom());
      qb.beat.y_start = coord_t'($urandom());
      qb.beat.x_end   = coord_t'($urandom());
      qb.beat.y_end   = coord_t'($urandom());
      qb.drain        = 1'b0;
      beats_to_send   = {beats_to_send, qb};
    end
  endtask

  // stimulus plan, then reset, then wait for the driver and the pixel stream to finish
  initial begin
    int line_beats;
    int pick;
    int x0;
    int y0;
    int x1;
    int y1;
    int reach;
    int span;
    int nsteps;

    // directed: step with no line running
    queue_steps(1);
    // full-range diagonal, abandoned by the next start
    queue_start(-2048, -2048, 2047, 2047, 1'b0);
    queue_steps(2);
    // both deltas negative, ends swapped
    queue_start(2047, 2047, -2048, -2048, 1'b0);
    queue_steps(2);
    // opposite corners, y mirrored
    queue_start(-2048, 2047, 2047, -2048, 1'b0);
    queue_steps(2);
    // equal endpoints, then a step that must be swallowed
    queue_start(5, 5, 5, 5, 1'b0);
    queue_steps(1);
    // leftward horizontal drawn out, plus one step past its end
    queue_start(3, 0, 0, 0, 1'b0);
    queue_steps(5);
    // upward vertical, held back until the leftward line has fully left
    queue_start(0, 0, 0, -2, 1'b1);
    queue_steps(3);

    // random: mostly short lines drawn to the end, some cut short or overrun,
    // a few full-range lines abandoned early, and loose steps as noise
    line_beats = 0;
    while (line_beats < RANDOM_BEATS) begin
      pick = $urandom_range(0, 19);
      if (pick == 0) begin
        queue_steps($urandom_range(1, 3));
      end else begin
        x0 = rand_coord();
        y0 = rand_coord();
        if (pick == 1) begin
          x1     = rand_coord();
          y1     = rand_coord();
          nsteps = $urandom_range(0, 30);
        end else begin
          reach = ($urandom_range(0, 7) == 0) ? 64 : 8;
          x1    = clamp_coord(x0 + int'($urandom_range(0, 2 * reach)) - reach);
          y1    = clamp_coord(y0 + int'($urandom_range(0, 2 * reach)) - reach);
          span  = (((x1 > x0) ? x1 - x0 : x0 - x1) > ((y1 > y0) ? y1 - y0 : y0 - y1)) ?
                  ((x1 > x0) ? x1 - x0 : x0 - x1) : ((y1 > y0) ? y1 - y0 : y0 - y1);
          span  = span + 1;
          case ($urandom_range(0, 5))
            0: begin
              nsteps = $urandom_range(0, span - 1);
            end
            1: begin
              nsteps = span + $urandom_range(1, 3);
            end
            default: begin
              nsteps = span;
            end
          endcase
        end
        queue_start(x0, y0, x1, y1, $urandom_range(0, 9) == 0);
        queue_steps(nsteps);
        line_beats += 1 + nsteps;
      end
    end

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_n = 1'b1;

    // sampled on the falling edge, clear of the clocked blocks
    while (beats_to_send.size() != 0 || in_valid) @(negedge clk_i);
    while (pixels_due.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);

    while (pixels_due.size() != 0) begin
      due_pixel = pixels_due.pop_front();
      flag_mismatch($sformatf("pixel (%0d,%0d) never arrived",
                              due_pixel.pixel_x, due_pixel.pixel_y));
    end

    if (mismatch_count == 0) begin
      $display("line_pixel_stepper verification clean");
    end else begin
      $display("line_pixel_stepper verification failed");
    end
    $finish;
  end

  // driver: bursts of back-to-back beats with random gaps; a drain beat is first held
  // back to see the registered all_drawn flag and goes out only once that flag is set
  always @(posedge clk_i or negedge rst_n) begin
    if (!rst_n) begin
      in_valid   <= 1'b0;
      in_data    <= '0;
      burst_left <= 0;
      gap_left   <= 0;
      drain_seen <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (gap_left != 0) begin
        in_valid <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (beats_to_send.size() == 0) begin
        in_valid <= 1'b0;
      end else if (beats_to_send[0].drain && !(drain_seen && all_drawn)) begin
        in_valid   <= 1'b0;
        drain_seen <= 1'b1;
      end else begin
        in_valid   <= 1'b1;
        in_data    <= beats_to_send[0].beat;
        drain_seen <= 1'b0;
        void'(beats_to_send.pop_front());
        if (burst_left == 0) begin
          burst_left <= $urandom_range(0, 24);
          // a third of the bursts run straight on with no gap
          gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end else begin
          burst_left <= burst_left - 1;
        end
      end
    end
  end

  // receiver: ready follows a rotating 16-bit pattern, replaced when pattern_age wraps;
  // bit 0 is always set so ready is high at least once in every rotation
  always @(posedge clk_i or negedge rst_n) begin
    if (!rst_n) begin
      out_ready     <= 1'b0;
      stall_pattern <= 16'hffff;
      pattern_age   <= '0;
    end else begin
      out_ready   <= stall_pattern[pattern_age[3:0]];
      pattern_age <= pattern_age + 8'd1;
      if (pattern_age == 8'hff) begin
        case ($urandom_range(0, 3))
          0: begin
            stall_pattern <= 16'hffff;
          end
          1: begin
            stall_pattern <= 16'h0001;
          end
          2: begin
            stall_pattern <= 16'($urandom() & $urandom()) | 16'h0001;
          end
          default: begin
            stall_pattern <= 16'($urandom()) | 16'h0001;
          end
        endcase
      end
    end
  end

  // monitor: output beats are checked before the new prediction is queued, so a
  // stray pixel can never pair with an expectation from the same edge
  always @(posedge clk_i or negedge rst_n) begin
    if (!rst_n) begin
      all_drawn <= 1'b1;
    end else begin
      if (out_valid && out_ready) begin
        if (pixels_due.size() == 0) begin
          flag_mismatch($sformatf("pixel (%0d,%0d) last=%0b with none due",
                                  out_data.pixel_x, out_data.pixel_y, out_data.last_pixel));
        end else begin
          due_pixel = pixels_due.pop_front();
          if (out_data.pixel_x !== due_pixel.pixel_x)
            flag_mismatch($sformatf("pixel_x %0d, due %0d",
                                    out_data.pixel_x, due_pixel.pixel_x));
          if (out_data.pixel_y !== due_pixel.pixel_y)
            flag_mismatch($sformatf("pixel_y %0d, due %0d",
                                    out_data.pixel_y, due_pixel.pixel_y));
          if (out_data.last_pixel !== due_pixel.last_pixel)
            flag_mismatch($sformatf("last_pixel %0b, due %0b at (%0d,%0d)",
                                    out_data.last_pixel, due_pixel.last_pixel,
                                    due_pixel.pixel_x, due_pixel.pixel_y));
        end
      end
      if (in_valid && in_ready) begin
        raster_next(in_data, fresh_valid, fresh_pixel);
        if (fresh_valid) pixels_due = {pixels_due, fresh_pixel};
      end
      all_drawn <= (pixels_due.size() == 0);
    end
  end

  // watchdog: any beat on either side restarts the count
  always @(posedge clk_i) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        stuck_cycles <= 0;
      end else if (stuck_cycles == WATCHDOG_LIMIT) begin
        $display("line_pixel_stepper verification failed");
        $finish;
      end else begin
        stuck_cycles <= stuck_cycles + 1;
      end
    end
  end

endmodule
